@@ design/aps_pkg.sv @@
// ----------------------------------------------------------------------------
// aps_pkg
// Shared types and codes of the aging priority scheduler: request kinds,
// result status codes, register indexes, and the slot, candidate and result records.
// ----------------------------------------------------------------------------
package aps_pkg;

	// request kinds
	typedef enum logic [1:0] {
		KIND_INSERT  = 2'd0,
		KIND_TAKE    = 2'd1,
		KIND_TICK    = 2'd2,
		KIND_RELEASE = 2'd3
	} kind_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// configuration register indexes
	localparam logic REG_AGING_RATE = 1'b0;
	localparam logic REG_HOT_BOOST  = 1'b1;

	// one stored job
	typedef struct packed {
		logic signed [7:0] prio;
		logic [31:0]       stamp;
		logic [31:0]       seq;
		logic              has_pin;
		logic [5:0]        pin;
	} slot_t;

	// a scored candidate leaving the evaluation pipeline
	typedef struct packed {
		slot_t              slot;
		logic [31:0]        age;
		logic signed [31:0] eff;
	} cand_t;

	// one result transaction
	typedef struct packed {
		status_t            status;
		logic signed [7:0]  taken_priority;
		logic signed [31:0] taken_effective;
		logic               taken_has_pin;
		logic [5:0]         taken_pin;
		logic [31:0]        taken_sequence;
	} rsp_t;

endpackage

@@ design/aps_req_if.sv @@
// ----------------------------------------------------------------------------
// aps_req_if
// Request channel of the scheduler: valid/ready plus one request item.
// ----------------------------------------------------------------------------
interface aps_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic signed [7:0] base_priority;
	logic              has_pin;
	logic [5:0]        pin_id;
	logic [1:0]        worker;

	modport source (output valid, kind, base_priority, has_pin, pin_id, worker, input ready);
	modport sink (input valid, kind, base_priority, has_pin, pin_id, worker, output ready);
endinterface

@@ design/aps_rsp_if.sv @@
// ----------------------------------------------------------------------------
// aps_rsp_if
// Result channel of the scheduler: valid/ready plus one result item.
// ----------------------------------------------------------------------------
interface aps_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [7:0]  taken_priority;
	logic signed [31:0] taken_effective;
	logic               taken_has_pin;
	logic [5:0]         taken_pin;
	logic [31:0]        taken_sequence;

	modport source (output valid, status, taken_priority, taken_effective, taken_has_pin,
		taken_pin, taken_sequence, input ready);
	modport sink (input valid, status, taken_priority, taken_effective, taken_has_pin,
		taken_pin, taken_sequence, output ready);
endinterface

@@ design/aps_cfg_if.sv @@
// ----------------------------------------------------------------------------
// aps_cfg_if
// Register write channel: valid/ready, register index and write data.
// ----------------------------------------------------------------------------
interface aps_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/aging_priority_scheduler.sv @@
// Insert: a one-slot-a-cycle search for the first free slot, then the result is loaded.
// Take: one slot read per cycle from the slot memory into the scoring pipeline, then the
// pipeline drains, the winner is written back, the result is loaded. Tick and release load theirs directly.
// One request is in progress at a time; the next is accepted the cycle after its result is loaded,
// and the result register lets it enter while a result waits. Asynchronous active-low reset
// empties the table, clears pins, time, sequence and both registers; slot contents stay as they are.
// ----------------------------------------------------------------------------
// aging_priority_scheduler
// Job table with aging priority, affinity pins per worker and tie break by
// insertion order, driven by a small sequencer around one scoring pipeline.
// ----------------------------------------------------------------------------
module aging_priority_scheduler #(
	parameter int ENTRIES = 16,
	parameter int WORKERS = 4,
	parameter int PINS    = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	aps_req_if.sink   req,
	aps_rsp_if.source rsp,
	aps_cfg_if.sink   cfg
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int WK_W  = (WORKERS > 1) ? $clog2(WORKERS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [1:0] DRAIN_LAST = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_SCAN,
		S_TAKE_SCAN,
		S_TAKE_DRAIN,
		S_TAKE_WB,
		S_RESULT
	} state_t;

	// one-hot mask of a pin id
	function automatic logic [PINS-1:0] pin_mask(input logic [5:0] p);
		logic [PINS-1:0] m;
		for (int i = 0; i < PINS; i++) begin
			m[i] = (p == 6'(i));
		end
		return m;
	endfunction

	state_t             state_q;
	logic [ENTRIES-1:0] valid_q;
	logic [PINS-1:0]    pins_q [WORKERS];
	logic [31:0]        now_q;
	logic [31:0]        next_seq_q;
	logic [15:0]        rate_q;
	logic signed [15:0] boost_q;
	logic signed [7:0]  base_q;
	logic               has_pin_q;
	logic [5:0]         pin_q;
	logic [1:0]         worker_q;
	logic [IDX_W-1:0]   scan_q;
	logic [1:0]         drain_q;
	logic               found_q;
	aps_pkg::cand_t     best_q;
	logic [IDX_W-1:0]   best_idx_q;
	aps_pkg::rsp_t      res_q;
	logic               rsp_valid_q;
	aps_pkg::rsp_t      out_q;

	aps_pkg::slot_t     slot_mem [ENTRIES];
	aps_pkg::slot_t     rd_s1;
	logic               live_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [IDX_W-1:0]   idx_s2;
	logic [IDX_W-1:0]   idx_s3;

	logic               req_fire;
	logic               cfg_fire;
	logic               worker_ok;
	logic [WK_W-1:0]    wk_idx;
	logic [PINS-1:0]    any_pins;
	logic [PINS-1:0]    mine;
	logic [PINS-1:0]    s1_mask;
	logic               s1_held;
	logic               s1_elig;
	logic               s1_boost;
	logic               mem_we;
	aps_pkg::slot_t     new_slot;
	logic               ev_valid;
	aps_pkg::cand_t     ev_cand;
	logic               better;

	assign req_fire  = req.valid && req.ready;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// requesting worker of the request in progress
	assign worker_ok = (int'(worker_q) < WORKERS);
	assign wk_idx    = WK_W'(worker_q);

	// pins held by any worker
	always_comb begin
		any_pins = '0;
		for (int w = 0; w < WORKERS; w++) begin
			any_pins = any_pins | pins_q[w];
		end
	end

	assign mine = worker_ok ? pins_q[wk_idx] : '0;

	// eligibility and boost of the slot leaving the memory
	assign s1_mask  = pin_mask(rd_s1.pin);
	assign s1_held  = |(any_pins & s1_mask);
	assign s1_elig  = !rd_s1.has_pin || (|(mine & s1_mask)) || !s1_held;
	assign s1_boost = rd_s1.has_pin && s1_held;

	// slot written on insert into the first free place
	assign mem_we = (state_q == S_INS_SCAN) && !valid_q[scan_q];
	always_comb begin
		new_slot         = '0;
		new_slot.prio    = base_q;
		new_slot.stamp   = now_q;
		new_slot.seq     = next_seq_q;
		new_slot.has_pin = has_pin_q;
		new_slot.pin     = has_pin_q ? pin_q : 6'd0;
	end

	// slot memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[scan_q] <= new_slot;
		end
		rd_s1 <= slot_mem[scan_q];
	end

	aps_eval u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (live_s1 && s1_elig),
		.in_slot   (rd_s1),
		.boost_en  (s1_boost),
		.now       (now_q),
		.next_seq  (next_seq_q),
		.rate      (rate_q),
		.boost     (boost_q),
		.out_valid (ev_valid),
		.out_cand  (ev_cand)
	);

	// higher effective priority, or equal and older
	assign better = !found_q || (ev_cand.eff > best_q.eff)
		|| ((ev_cand.eff == best_q.eff) && (ev_cand.age > best_q.age));

	// sequencer, table state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			for (int w = 0; w < WORKERS; w++) begin
				pins_q[w] <= '0;
			end
			now_q       <= '0;
			next_seq_q  <= '0;
			rate_q      <= '0;
			boost_q     <= '0;
			base_q      <= '0;
			has_pin_q   <= 1'b0;
			pin_q       <= '0;
			worker_q    <= '0;
			scan_q      <= '0;
			drain_q     <= '0;
			found_q     <= 1'b0;
			best_q      <= '0;
			best_idx_q  <= '0;
			res_q       <= '0;
			rsp_valid_q <= 1'b0;
			out_q       <= '0;
			live_s1     <= 1'b0;
			idx_s1      <= '0;
			idx_s2      <= '0;
			idx_s3      <= '0;
		end else begin
			// register writes
			if (cfg_fire) begin
				case (cfg.index)
					aps_pkg::REG_AGING_RATE: rate_q <= cfg.data;
					aps_pkg::REG_HOT_BOOST:  boost_q <= $signed(cfg.data);
					default: ;
				endcase
			end

			// scan index alongside the pipeline
			live_s1 <= (state_q == S_TAKE_SCAN) && valid_q[scan_q];
			idx_s1  <= scan_q;
			idx_s2  <= idx_s1;
			idx_s3  <= idx_s2;

			// keep the best candidate seen so far
			if (ev_valid && better) begin
				found_q    <= 1'b1;
				best_q     <= ev_cand;
				best_idx_q <= idx_s3;
			end

			// result transaction taken downstream
			if (rsp_valid_q && rsp.ready && (state_q != S_RESULT)) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						base_q    <= req.base_priority;
						has_pin_q <= req.has_pin && (int'(req.pin_id) < PINS);
						pin_q     <= req.pin_id;
						worker_q  <= req.worker;
						scan_q    <= '0;
						found_q   <= 1'b0;
						res_q     <= '0;
						case (aps_pkg::kind_t'(req.kind))
							aps_pkg::KIND_INSERT: state_q <= S_INS_SCAN;
							aps_pkg::KIND_TAKE:   state_q <= S_TAKE_SCAN;
							aps_pkg::KIND_TICK: begin
								now_q   <= now_q + 32'd1;
								state_q <= S_RESULT;
							end
							aps_pkg::KIND_RELEASE: begin
								if (int'(req.worker) < WORKERS) begin
									pins_q[WK_W'(req.worker)] <= '0;
								end
								state_q <= S_RESULT;
							end
							default: state_q <= S_RESULT;
						endcase
					end
				end

				// one slot a cycle until a free one turns up or the last slot is found taken
				S_INS_SCAN: begin
					if (!valid_q[scan_q]) begin
						valid_q[scan_q] <= 1'b1;
						next_seq_q      <= next_seq_q + 32'd1;
						res_q.status    <= aps_pkg::STAT_OK;
						state_q         <= S_RESULT;
					end else if (scan_q == LAST_IDX) begin
						res_q.status <= aps_pkg::STAT_FULL;
						state_q      <= S_RESULT;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end

				// read every slot; valid, eligible ones enter the scoring pipeline
				S_TAKE_SCAN: begin
					if (scan_q == LAST_IDX) begin
						drain_q <= '0;
						state_q <= S_TAKE_DRAIN;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end

				S_TAKE_DRAIN: begin
					if (drain_q == DRAIN_LAST) begin
						state_q <= S_TAKE_WB;
					end else begin
						drain_q <= drain_q + 2'd1;
					end
				end

				// remove the winner and record its pin, or report empty if none was found
				S_TAKE_WB: begin
					if (found_q) begin
						valid_q[best_idx_q]   <= 1'b0;
						if (best_q.slot.has_pin && worker_ok) begin
							pins_q[wk_idx] <= pins_q[wk_idx] | pin_mask(best_q.slot.pin);
						end
						res_q.status          <= aps_pkg::STAT_OK;
						res_q.taken_priority  <= best_q.slot.prio;
						res_q.taken_effective <= best_q.eff;
						res_q.taken_has_pin   <= best_q.slot.has_pin;
						res_q.taken_pin       <= best_q.slot.pin;
						res_q.taken_sequence  <= best_q.slot.seq;
					end else begin
						res_q.status <= aps_pkg::STAT_EMPTY;
					end
					state_q <= S_RESULT;
				end

				// hand over once the result register is free
				S_RESULT: begin
					if (!rsp_valid_q || rsp.ready) begin
						out_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result channel
	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = out_q.status;
	assign rsp.taken_priority  = out_q.taken_priority;
	assign rsp.taken_effective = out_q.taken_effective;
	assign rsp.taken_has_pin   = out_q.taken_has_pin;
	assign rsp.taken_pin       = out_q.taken_pin;
	assign rsp.taken_sequence  = out_q.taken_sequence;

endmodule

@@ design/aps_eval.sv @@
// ----------------------------------------------------------------------------
// aps_eval
// Two-stage scoring pipeline shared by every slot of a take scan: aged
// priority product, then sum with base and boost and saturation to 32 bits.
// ----------------------------------------------------------------------------
module aps_eval (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  aps_pkg::slot_t      in_slot,
	input  logic                boost_en,
	input  logic [31:0]         now,
	input  logic [31:0]         next_seq,
	input  logic [15:0]         rate,
	input  logic signed [15:0]  boost,
	output logic                out_valid,
	output aps_pkg::cand_t      out_cand
);

	localparam logic signed [41:0] SAT_HI = 42'sd2147483647;
	localparam logic signed [41:0] SAT_LO = -SAT_HI - 42'sd1;

	logic               v_s2;
	logic [47:0]        prod_s2;
	aps_pkg::slot_t     slot_s2;
	logic signed [15:0] boost_s2;
	logic [31:0]        age_s2;
	logic               v_s3;
	aps_pkg::cand_t     cand_s3;
	logic [31:0]        wait_ticks;
	logic signed [41:0] sum;

	// wait since insertion, mod 2^32
	assign wait_ticks = now - in_slot.stamp;

	// aged priority with base and boost, full precision
	assign sum = $signed({2'b00, prod_s2[47:8]}) + 42'($signed(slot_s2.prio))
		+ 42'($signed(boost_s2));

	// stage 2: multiply, age, boost select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			prod_s2  <= '0;
			slot_s2  <= '0;
			boost_s2 <= '0;
			age_s2   <= '0;
		end else begin
			v_s2     <= in_valid;
			prod_s2  <= wait_ticks * rate;
			slot_s2  <= in_slot;
			boost_s2 <= boost_en ? boost : 16'sd0;
			age_s2   <= next_seq - in_slot.seq;
		end
	end

	// stage 3: sum and saturate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3    <= 1'b0;
			cand_s3 <= '0;
		end else begin
			v_s3         <= v_s2;
			cand_s3.slot <= slot_s2;
			cand_s3.age  <= age_s2;
			if (sum > SAT_HI) begin
				cand_s3.eff <= 32'sh7FFFFFFF;
			end else if (sum < SAT_LO) begin
				cand_s3.eff <= 32'sh80000000;
			end else begin
				cand_s3.eff <= 32'(sum);
			end
		end
	end

	assign out_valid = v_s3;
	assign out_cand  = cand_s3;

endmodule

@@ design/aps_checker.sv @@
// ----------------------------------------------------------------------------
// aps_checker
// Port-level checks of the scheduler: request/result pairing, status codes
// against the request kind, and empty payload on failed requests.
// ----------------------------------------------------------------------------
module aps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [1:0]  req_kind,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic [31:0] rsp_effective,
	input logic [31:0] rsp_sequence
);

	logic [1:0] kind_q;

	// kind of the last accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= aps_pkg::KIND_TICK;
		end else if (req_valid && req_ready) begin
			kind_q <= req_kind;
		end
	end

	// one request in progress at a time
	a_single_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in progress");

	// a pending result holds until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_sequence))
		else $error("result dropped or changed before transaction");

	// table full only answers an insert, nothing eligible only a take
	a_status_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && $rose(rsp_valid) |->
		(rsp_status == aps_pkg::STAT_OK)
		|| (rsp_status == aps_pkg::STAT_FULL && kind_q == aps_pkg::KIND_INSERT)
		|| (rsp_status == aps_pkg::STAT_EMPTY && kind_q == aps_pkg::KIND_TAKE))
		else $error("status does not match request kind");

	// failed requests carry no job
	a_fail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != aps_pkg::STAT_OK |->
		rsp_effective == 32'd0 && rsp_sequence == 32'd0)
		else $error("payload present on failed request");

endmodule

bind aging_priority_scheduler aps_checker u_aps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_kind      (req.kind),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_status    (rsp.status),
	.rsp_effective (rsp.taken_effective),
	.rsp_sequence  (rsp.taken_sequence)
);
